### src/i2cram_pkg.sv
package i2cram_pkg;

  // opcodes of a command word
  localparam logic [1:0] OP_WRITE_BYTE = 2'd0;
  localparam logic [1:0] OP_READ_BYTE  = 2'd1;
  localparam logic [1:0] OP_READ_WORD  = 2'd2;

  // write address byte of the target device after reset
  localparam logic [7:0] DEV_ADDR_RESET = 8'hD0;

  // bits in one byte on the bus
  localparam logic [3:0] BYTE_BITS = 4'd8;

  // bus sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_RSTART_LO,
    PH_START_HI,
    PH_START_LO,
    PH_TX_LO,
    PH_TX_HI,
    PH_ACK_LO,
    PH_ACK_HI,
    PH_RX_LO,
    PH_RX_HI,
    PH_NACK_LO,
    PH_NACK_HI,
    PH_STOP_A,
    PH_STOP_B,
    PH_STOP_C
  } phase_t;

  // one input word per half-bit tick
  typedef struct packed {
    logic       command_valid;
    logic [1:0] opcode;
    logic [7:0] register_address;
    logic [7:0] write_data;
    logic       sda_sample;
  } in_t;

  // one result word per tick
  typedef struct packed {
    logic        scl_level;
    logic        sda_level;
    logic        busy_res;
    logic        done_res;
    logic [15:0] read_value;
  } out_t;

endpackage

### src/i2c_register_access_master_top.sv
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    in_data   (i2cram_pkg::in_t)
// out       output     out_valid / out_ready  out_data  (i2cram_pkg::out_t)
// config    input      config_write           config_data (device address byte)
//
// every input word yields exactly one result word; a word is held in the input
// register, the tick update runs there, and the result is registered in the output
// register, so throughput is one word per cycle while out_ready does not stall.
// rst is synchronous: phase idle, counters and held command zero, address 0xD0.
// a stall on out_ready holds the output register; the input register still takes
// one more word, and in_ready drops only while both registers are full.
module i2c_register_access_master_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              config_write,
  input  logic [7:0]        config_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  i2cram_pkg::in_t   in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output i2cram_pkg::out_t  out_data
);
  import i2cram_pkg::*;

  // configuration register
  logic [7:0] dev_addr;

  // input register stage
  logic in_q_valid;
  in_t  in_q;
  logic advance;

  // tick state
  phase_t     phase, phase_next, eff_phase;
  logic [3:0] bit_count, bit_count_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [1:0] byte_step, byte_step_next;
  logic       second_read, second_read_next;
  logic [1:0] held_op, held_op_next;
  logic [7:0] held_reg, held_reg_next;
  logic [7:0] held_data, held_data_next;
  logic [15:0] result_word, result_word_next;

  logic       start;
  logic [3:0] bit_count_inc;
  logic       last_read;
  out_t       res;

  // handshake between the two register stages
  assign advance  = in_q_valid && (!out_valid || out_ready);
  assign in_ready = !in_q_valid || !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dev_addr <= DEV_ADDR_RESET;
    end else if (config_write) begin
      dev_addr <= config_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
  end

  // a command is taken only on an idle tick with a legal opcode
  assign start = (phase == PH_IDLE) && in_q.command_valid &&
                 (in_q.opcode <= OP_READ_WORD);
  assign eff_phase = start ? PH_START_HI : phase;
  assign bit_count_inc = bit_count + 4'd1;
  assign last_read = (held_op == OP_READ_WORD) ? second_read : 1'b1;

  // next state
  always_comb begin
    phase_next       = phase;
    bit_count_next   = bit_count;
    shift_byte_next  = shift_byte;
    byte_step_next   = byte_step;
    second_read_next = second_read;
    held_op_next     = held_op;
    held_reg_next    = held_reg;
    held_data_next   = held_data;
    result_word_next = result_word;
    if (start) begin
      held_op_next     = in_q.opcode;
      held_reg_next    = in_q.register_address;
      held_data_next   = in_q.write_data;
      second_read_next = 1'b0;
      byte_step_next   = 2'd0;
      bit_count_next   = 4'd0;
    end
    unique case (eff_phase)
      PH_RSTART_LO: phase_next = PH_START_HI;
      PH_START_HI:  phase_next = PH_START_LO;
      PH_START_LO: begin
        shift_byte_next = (byte_step_next == 2'd0) ? dev_addr : dev_addr + 8'd1;
        bit_count_next  = 4'd0;
        phase_next      = PH_TX_LO;
      end
      PH_TX_LO: phase_next = PH_TX_HI;
      PH_TX_HI: begin
        shift_byte_next = {shift_byte[6:0], 1'b0};
        bit_count_next  = bit_count_inc;
        phase_next      = (bit_count_inc >= BYTE_BITS) ? PH_ACK_LO : PH_TX_LO;
      end
      PH_ACK_LO: phase_next = PH_ACK_HI;
      PH_ACK_HI: begin
        if (byte_step == 2'd0) begin
          byte_step_next  = 2'd1;
          shift_byte_next = held_reg + {7'd0, second_read};
          bit_count_next  = 4'd0;
          phase_next      = PH_TX_LO;
        end else if (held_op == OP_WRITE_BYTE) begin
          if (byte_step == 2'd1) begin
            byte_step_next  = 2'd2;
            shift_byte_next = held_data;
            bit_count_next  = 4'd0;
            phase_next      = PH_TX_LO;
          end else begin
            phase_next = PH_STOP_A;
          end
        end else if (byte_step == 2'd1) begin
          byte_step_next = 2'd2;
          phase_next     = PH_RSTART_LO;
        end else begin
          shift_byte_next = 8'd0;
          bit_count_next  = 4'd0;
          phase_next      = PH_RX_LO;
        end
      end
      PH_RX_LO: phase_next = PH_RX_HI;
      PH_RX_HI: begin
        shift_byte_next = {shift_byte[6:0], in_q.sda_sample};
        bit_count_next  = bit_count_inc;
        phase_next      = (bit_count_inc >= BYTE_BITS) ? PH_NACK_LO : PH_RX_LO;
      end
      PH_NACK_LO: phase_next = PH_NACK_HI;
      PH_NACK_HI: phase_next = PH_STOP_A;
      PH_STOP_A:  phase_next = PH_STOP_B;
      PH_STOP_B:  phase_next = PH_STOP_C;
      PH_STOP_C: begin
        if (!last_read) begin
          // first half of a word read: keep the high byte
          held_data_next   = shift_byte;
          second_read_next = 1'b1;
          byte_step_next   = 2'd0;
          phase_next       = PH_START_HI;
        end else begin
          if (held_op == OP_READ_BYTE) begin
            result_word_next = {8'd0, shift_byte};
          end else if (held_op == OP_READ_WORD) begin
            result_word_next = {held_data, shift_byte};
          end
          phase_next = PH_IDLE;
        end
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  // bus levels and status for this tick
  always_comb begin
    res.scl_level  = 1'b1;
    res.sda_level  = 1'b1;
    res.busy_res   = 1'b1;
    res.done_res   = 1'b0;
    res.read_value = result_word_next;
    unique case (eff_phase)
      PH_IDLE:      res.busy_res = 1'b0;
      PH_RSTART_LO: res.scl_level = 1'b0;
      PH_START_HI:  res.scl_level = 1'b1;
      PH_START_LO:  res.sda_level = 1'b0;
      PH_TX_LO: begin
        res.scl_level = 1'b0;
        res.sda_level = shift_byte[7];
      end
      PH_TX_HI:     res.sda_level = shift_byte[7];
      PH_ACK_LO, PH_RX_LO, PH_NACK_LO: res.scl_level = 1'b0;
      PH_ACK_HI, PH_RX_HI, PH_NACK_HI: res.scl_level = 1'b1;
      PH_STOP_A: begin
        res.scl_level = 1'b0;
        res.sda_level = 1'b0;
      end
      PH_STOP_B:    res.sda_level = 1'b0;
      PH_STOP_C:    res.done_res = last_read;
      default:      res.busy_res = 1'b1;
    endcase
  end

  // state registers, updated as each word leaves the input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      bit_count   <= 4'd0;
      shift_byte  <= 8'd0;
      byte_step   <= 2'd0;
      second_read <= 1'b0;
      held_op     <= OP_WRITE_BYTE;
      held_reg    <= 8'd0;
      held_data   <= 8'd0;
      result_word <= 16'd0;
    end else if (advance) begin
      phase       <= phase_next;
      bit_count   <= bit_count_next;
      shift_byte  <= shift_byte_next;
      byte_step   <= byte_step_next;
      second_read <= second_read_next;
      held_op     <= held_op_next;
      held_reg    <= held_reg_next;
      held_data   <= held_data_next;
      result_word <= result_word_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res;
    end
  end

endmodule
